// ===== rtl/core/aarp_pkg.sv =====
// Package for the pivot rotation block: item types, fixed-point constants
// and reciprocal constants for the sine and cosine series.
// No dependencies.
package aarp_pkg;

    // One input item: pivot (Q16.16), axis (Q2.14), angle (Q16.16).
    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic signed [31:0] angle;
    } t_in_item;

    // One result item: rotation in Q2.14, translation column in Q16.16.
    typedef struct packed {
        logic signed [15:0] r00;
        logic signed [15:0] r01;
        logic signed [15:0] r02;
        logic signed [15:0] r10;
        logic signed [15:0] r11;
        logic signed [15:0] r12;
        logic signed [15:0] r20;
        logic signed [15:0] r21;
        logic signed [15:0] r22;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] shift_z;
    } t_out_item;

    // Pivot and axis travelling beside the angle pipeline.
    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
    } t_pivot;

    // Quadrant of the binary phase.
    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } t_quad;

    // One in Q2.30 and pi in Q2.30.
    localparam logic [30:0] ONE_Q30 = 31'd1073741824;
    localparam logic [31:0] PI_Q30  = 32'd3373259426;

    // Turns per radian scaled to a 32 bit phase, split for two multipliers.
    localparam logic [45:0] TURN_K = 46'd44798133900177;
    localparam logic [22:0] TURN_K_LO = TURN_K[22:0];
    localparam logic [22:0] TURN_K_HI = TURN_K[45:23];

    // Series divisors.
    localparam logic [5:0] DIV_S1 = 6'd42;
    localparam logic [5:0] DIV_S2 = 6'd20;
    localparam logic [5:0] DIV_S3 = 6'd6;
    localparam logic [5:0] DIV_C1 = 6'd56;
    localparam logic [5:0] DIV_C2 = 6'd30;
    localparam logic [5:0] DIV_C3 = 6'd12;

    // Reciprocals floor(2^32 / d); the quotient is then at most one low.
    localparam logic [29:0] RCP_S1 = 30'((64'd1 << 32) / 64'(DIV_S1));
    localparam logic [29:0] RCP_S2 = 30'((64'd1 << 32) / 64'(DIV_S2));
    localparam logic [29:0] RCP_S3 = 30'((64'd1 << 32) / 64'(DIV_S3));
    localparam logic [29:0] RCP_C1 = 30'((64'd1 << 32) / 64'(DIV_C1));
    localparam logic [29:0] RCP_C2 = 30'((64'd1 << 32) / 64'(DIV_C2));
    localparam logic [29:0] RCP_C3 = 30'((64'd1 << 32) / 64'(DIV_C3));

    // Register stages in the sine and cosine unit.
    localparam int TRIG_LAT = 13;

endpackage

// ===== rtl/core/axis_angle_rotation_about_point_3d.sv =====
// Rotation about a pivot: a new item may start in every cycle (busy is low
// whenever reset is released). The depth is set by the 13 stage sine and
// cosine unit, the two stage angle multiplier and the seven stage matrix and
// translation path. Synchronous reset empties the pipeline.
module axis_angle_rotation_about_point_3d (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  aarp_pkg::t_in_item   i_item,
    output logic                 o_strobe,
    output aarp_pkg::t_out_item  o_result
);
    import aarp_pkg::*;

    localparam int SB_LEN  = TRIG_LAT + 2;
    localparam int LATENCY = SB_LEN + 7;

    // Round half up from Q.58 to Q2.14 and saturate.
    function automatic logic signed [15:0] rnd_sat16(input logic signed [63:0] f);
        logic signed [63:0] t;
        logic signed [19:0] h;
        t = f + (64'sd1 <<< 43);
        h = t[63:44];
        if (h > 20'sd32767) begin
            rnd_sat16 = 16'sh7fff;
        end else if (h < -20'sd32768) begin
            rnd_sat16 = 16'sh8000;
        end else begin
            rnd_sat16 = h[15:0];
        end
    endfunction

    // Round half up from Q.30 to Q16.16 and saturate.
    function automatic logic signed [31:0] rnd_sat32(input logic signed [49:0] a);
        logic signed [49:0] t;
        logic signed [35:0] h;
        t = a + (50'sd1 <<< 13);
        h = t[49:14];
        if (h > 36'sd2147483647) begin
            rnd_sat32 = 32'sh7fff_ffff;
        end else if (h < -36'sd2147483648) begin
            rnd_sat32 = 32'sh8000_0000;
        end else begin
            rnd_sat32 = h[31:0];
        end
    endfunction

    logic               w_accept;
    logic [1:0]         r_pv;
    logic signed [55:0] r_plo, r_phi;
    logic [63:0]        w_pk;
    logic [31:0]        r_phase;
    t_pivot             r_sb [0:SB_LEN-1];

    logic               w_trig_vld;
    logic signed [31:0] w_sin, w_cos;

    logic [6:0]         r_mv;
    logic signed [31:0] r_pt_x [0:4];
    logic signed [31:0] r_pt_y [0:4];
    logic signed [31:0] r_pt_z [0:4];
    logic signed [31:0] r_uu00, r_uu11, r_uu22, r_uu01, r_uu02, r_uu12;
    logic signed [32:0] r_om;
    logic signed [47:0] r_us0, r_us1, r_us2, r_us0b, r_us1b, r_us2b;
    logic signed [31:0] r_cs, r_csb;
    logic signed [63:0] r_a00, r_a11, r_a22, r_a01, r_a02, r_a12;
    logic signed [63:0] r_f [0:8];
    logic signed [15:0] r_r [0:8];
    logic signed [15:0] r_r4 [0:8];
    logic signed [15:0] r_r5 [0:8];
    logic signed [47:0] r_rp [0:8];
    logic signed [49:0] r_acc [0:2];
    t_out_item          r_out;

    // Items are taken whenever reset is released.
    assign busy     = !i_rst_n;
    assign w_accept = start && !busy;

    // Front valid bits and the matrix path's valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
            r_mv <= '0;
        end else begin
            r_pv <= {r_pv[0], w_accept};
            r_mv <= {r_mv[5:0], w_trig_vld};
        end
    end

    // Angle to binary phase: two partial products, then their sum.
    assign w_pk = ({{8{r_phi[55]}}, r_phi} << 23) + {{8{r_plo[55]}}, r_plo};

    always_ff @(posedge i_clk) begin
        r_plo   <= $signed(i_item.angle) * $signed({1'b0, TURN_K_LO});
        r_phi   <= $signed(i_item.angle) * $signed({1'b0, TURN_K_HI});
        r_phase <= w_pk[63:32];
    end

    // Pivot and axis wait beside the angle path.
    always_ff @(posedge i_clk) begin
        r_sb[0] <= '{point_x: i_item.point_x, point_y: i_item.point_y,
                     point_z: i_item.point_z, axis_x: i_item.axis_x,
                     axis_y: i_item.axis_y, axis_z: i_item.axis_z};
        for (int k = 1; k < SB_LEN; k++) begin
            r_sb[k] <= r_sb[k-1];
        end
    end

    aarp_trig u_trig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_pv[1]),
        .i_phase (r_phase),
        .o_valid (w_trig_vld),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    // Axis products, one minus cosine and the sine cross terms.
    always_ff @(posedge i_clk) begin
        r_uu00 <= r_sb[SB_LEN-1].axis_x * r_sb[SB_LEN-1].axis_x;
        r_uu11 <= r_sb[SB_LEN-1].axis_y * r_sb[SB_LEN-1].axis_y;
        r_uu22 <= r_sb[SB_LEN-1].axis_z * r_sb[SB_LEN-1].axis_z;
        r_uu01 <= r_sb[SB_LEN-1].axis_x * r_sb[SB_LEN-1].axis_y;
        r_uu02 <= r_sb[SB_LEN-1].axis_x * r_sb[SB_LEN-1].axis_z;
        r_uu12 <= r_sb[SB_LEN-1].axis_y * r_sb[SB_LEN-1].axis_z;
        r_om   <= 33'sd1073741824 - 33'(w_cos);
        r_us0  <= r_sb[SB_LEN-1].axis_x * w_sin;
        r_us1  <= r_sb[SB_LEN-1].axis_y * w_sin;
        r_us2  <= r_sb[SB_LEN-1].axis_z * w_sin;
        r_cs   <= w_cos;
        r_pt_x[0] <= r_sb[SB_LEN-1].point_x;
        r_pt_y[0] <= r_sb[SB_LEN-1].point_y;
        r_pt_z[0] <= r_sb[SB_LEN-1].point_z;
        for (int k = 1; k < 5; k++) begin
            r_pt_x[k] <= r_pt_x[k-1];
            r_pt_y[k] <= r_pt_y[k-1];
            r_pt_z[k] <= r_pt_z[k-1];
        end
    end

    // Symmetric part scaled by one minus cosine.
    always_ff @(posedge i_clk) begin
        r_a00  <= r_uu00 * r_om;
        r_a11  <= r_uu11 * r_om;
        r_a22  <= r_uu22 * r_om;
        r_a01  <= r_uu01 * r_om;
        r_a02  <= r_uu02 * r_om;
        r_a12  <= r_uu12 * r_om;
        r_us0b <= r_us0;
        r_us1b <= r_us1;
        r_us2b <= r_us2;
        r_csb  <= r_cs;
    end

    // Full precision entries, then rounding to Q2.14.
    always_ff @(posedge i_clk) begin
        r_f[0] <= r_a00 + (64'(r_csb) <<< 28);
        r_f[4] <= r_a11 + (64'(r_csb) <<< 28);
        r_f[8] <= r_a22 + (64'(r_csb) <<< 28);
        r_f[1] <= r_a01 - (64'(r_us2b) <<< 14);
        r_f[3] <= r_a01 + (64'(r_us2b) <<< 14);
        r_f[2] <= r_a02 + (64'(r_us1b) <<< 14);
        r_f[6] <= r_a02 - (64'(r_us1b) <<< 14);
        r_f[5] <= r_a12 - (64'(r_us0b) <<< 14);
        r_f[7] <= r_a12 + (64'(r_us0b) <<< 14);
        for (int k = 0; k < 9; k++) begin
            r_r[k]  <= rnd_sat16(r_f[k]);
            r_r4[k] <= r_r[k];
            r_r5[k] <= r_r4[k];
        end
    end

    // Translation column p - R*p from the rounded rotation.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_rp[i*3]   <= r_r[i*3]   * r_pt_x[3];
            r_rp[i*3+1] <= r_r[i*3+1] * r_pt_y[3];
            r_rp[i*3+2] <= r_r[i*3+2] * r_pt_z[3];
        end
        r_acc[0] <= (50'(r_pt_x[4]) <<< 14) - 50'(r_rp[0]) - 50'(r_rp[1]) - 50'(r_rp[2]);
        r_acc[1] <= (50'(r_pt_y[4]) <<< 14) - 50'(r_rp[3]) - 50'(r_rp[4]) - 50'(r_rp[5]);
        r_acc[2] <= (50'(r_pt_z[4]) <<< 14) - 50'(r_rp[6]) - 50'(r_rp[7]) - 50'(r_rp[8]);
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        r_out.r00     <= r_r5[0];
        r_out.r01     <= r_r5[1];
        r_out.r02     <= r_r5[2];
        r_out.r10     <= r_r5[3];
        r_out.r11     <= r_r5[4];
        r_out.r12     <= r_r5[5];
        r_out.r20     <= r_r5[6];
        r_out.r21     <= r_r5[7];
        r_out.r22     <= r_r5[8];
        r_out.shift_x <= rnd_sat32(r_acc[0]);
        r_out.shift_y <= rnd_sat32(r_acc[1]);
        r_out.shift_z <= rnd_sat32(r_acc[2]);
    end

    assign o_strobe = r_mv[6];
    assign o_result = r_out;

`ifndef SYNTH
    // Every result comes from an item taken exactly one latency earlier.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_accept, LATENCY))
        else $error("result strobe without a matching item");

    // The trig unit stays aligned with the pivot line.
    a_trig_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_trig_vld |-> $past(w_accept, SB_LEN))
        else $error("sine and cosine out of step with the pivot line");

    // Sine and cosine never exceed one in magnitude.
    a_trig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_trig_vld |-> (w_sin <= 32'sd1073741824 && w_sin >= -32'sd1073741824 &&
                        w_cos <= 32'sd1073741824 && w_cos >= -32'sd1073741824))
        else $error("sine or cosine out of range");
`endif

endmodule

// ===== rtl/core/aarp_trig.sv =====
// Pipelined sine and cosine of a 32 bit binary phase, Q2.30 results.
// Depends on aarp_pkg.
module aarp_trig (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic        [31:0] i_phase,
    output logic               o_valid,
    output logic signed [31:0] o_sin,
    output logic signed [31:0] o_cos
);
    import aarp_pkg::*;

    typedef struct packed {
        logic [29:0] x;
        logic [29:0] x2;
        t_quad       q;
        logic        neg;
    } t_trig_side;

    // Product of two Q.30 values, truncated back to Q.30.
    function automatic logic [29:0] mul_q30(input logic [29:0] a, input logic [30:0] b);
        logic [60:0] p;
        p = 61'(a) * 61'(b);
        mul_q30 = p[59:30];
    endfunction

    // First guess of a quotient by reciprocal multiplication.
    function automatic logic [29:0] rcp_quo(input logic [29:0] v, input logic [29:0] m);
        logic [59:0] p;
        p = 60'(v) * 60'(m);
        rcp_quo = 30'(p[59:32]);
    endfunction

    // Correct the first guess, which is exact or one low; return one minus it.
    function automatic logic [30:0] one_minus_quo(input logic [29:0] v,
                                                  input logic [29:0] q0,
                                                  input logic [5:0]  d);
        logic [35:0] rem;
        logic [29:0] q;
        rem = 36'(v) - 36'(q0) * 36'(d);
        q = (rem >= 36'(d)) ? q0 + 30'd1 : q0;
        one_minus_quo = ONE_Q30 - 31'(q);
    endfunction

    logic [TRIG_LAT-1:0] r_vld;
    t_trig_side          r_sd [0:11];
    logic [29:0]         r_m;
    logic [29:0]         r_q3s, r_q3c, r_q6s, r_q6c, r_q9s, r_q9c;
    logic [29:0]         r_p5s, r_p5c, r_p6s, r_p6c, r_p8s, r_p8c, r_p9s, r_p9c;
    logic [30:0]         r_t4s, r_t4c, r_t7s, r_t7c, r_t10s, r_t10c;
    logic [29:0]         r_s11, r_p11c;
    logic signed [31:0]  r_sin, r_cos;

    logic [31:0]        w_ph2, w_d, w_mag;
    t_quad              w_q;
    logic [61:0]        w_xp;
    logic [30:0]        w_c;
    logic signed [31:0] w_s, w_cs;

    // Quadrant and signed residual of the phase, and the registered residual times pi.
    always_comb begin
        w_ph2 = i_phase + 32'h2000_0000;
        w_q   = t_quad'(w_ph2[31:30]);
        w_d   = i_phase - {w_ph2[31:30], 30'd0};
        w_mag = w_d[31] ? 32'd0 - w_d : w_d;
        w_xp  = 62'(r_m) * 62'(PI_Q30);
    end

    // Final sign and cosine tail; the quadrant mapping follows in the last data stage.
    always_comb begin
        w_c  = ONE_Q30 - {2'b00, r_p11c[29:1]};
        w_s  = r_sd[11].neg ? 32'sd0 - 32'(r_s11) : 32'(r_s11);
        w_cs = 32'(w_c);
    end

    // Valid bits travel beside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[TRIG_LAT-2:0], i_valid};
        end
    end

    // Data stages.
    always_ff @(posedge i_clk) begin
        r_m          <= w_mag[29:0];
        r_sd[0].q    <= w_q;
        r_sd[0].neg  <= w_d[31];
        r_sd[0].x    <= '0;
        r_sd[0].x2   <= '0;
        r_sd[1].q    <= r_sd[0].q;
        r_sd[1].neg  <= r_sd[0].neg;
        r_sd[1].x    <= w_xp[60:31];
        r_sd[1].x2   <= '0;
        r_sd[2].q    <= r_sd[1].q;
        r_sd[2].neg  <= r_sd[1].neg;
        r_sd[2].x    <= r_sd[1].x;
        r_sd[2].x2   <= mul_q30(r_sd[1].x, 31'(r_sd[1].x));
        for (int k = 3; k < 12; k++) begin
            r_sd[k] <= r_sd[k-1];
        end

        // First series term.
        r_q3s  <= rcp_quo(r_sd[2].x2, RCP_S1);
        r_q3c  <= rcp_quo(r_sd[2].x2, RCP_C1);
        r_t4s  <= one_minus_quo(r_sd[3].x2, r_q3s, DIV_S1);
        r_t4c  <= one_minus_quo(r_sd[3].x2, r_q3c, DIV_C1);

        // Second series term.
        r_p5s  <= mul_q30(r_sd[4].x2, r_t4s);
        r_p5c  <= mul_q30(r_sd[4].x2, r_t4c);
        r_q6s  <= rcp_quo(r_p5s, RCP_S2);
        r_q6c  <= rcp_quo(r_p5c, RCP_C2);
        r_p6s  <= r_p5s;
        r_p6c  <= r_p5c;
        r_t7s  <= one_minus_quo(r_p6s, r_q6s, DIV_S2);
        r_t7c  <= one_minus_quo(r_p6c, r_q6c, DIV_C2);

        // Third series term.
        r_p8s  <= mul_q30(r_sd[7].x2, r_t7s);
        r_p8c  <= mul_q30(r_sd[7].x2, r_t7c);
        r_q9s  <= rcp_quo(r_p8s, RCP_S3);
        r_q9c  <= rcp_quo(r_p8c, RCP_C3);
        r_p9s  <= r_p8s;
        r_p9c  <= r_p8c;
        r_t10s <= one_minus_quo(r_p9s, r_q9s, DIV_S3);
        r_t10c <= one_minus_quo(r_p9c, r_q9c, DIV_C3);

        // Last products.
        r_s11  <= mul_q30(r_sd[10].x, r_t10s);
        r_p11c <= mul_q30(r_sd[10].x2, r_t10c);

        case (r_sd[11].q)
            QUAD_0: begin
                r_sin <= w_s;
                r_cos <= w_cs;
            end
            QUAD_90: begin
                r_sin <= w_cs;
                r_cos <= 32'sd0 - w_s;
            end
            QUAD_180: begin
                r_sin <= 32'sd0 - w_s;
                r_cos <= 32'sd0 - w_cs;
            end
            default: begin
                r_sin <= 32'sd0 - w_cs;
                r_cos <= w_s;
            end
        endcase
    end

    assign o_valid = r_vld[TRIG_LAT-1];
    assign o_sin   = r_sin;
    assign o_cos   = r_cos;

endmodule
